// ===== sv/tma_pkg.sv =====
// Shared types and constants for the trailing moving average block.
// Used by the interfaces, the controller, the datapath and the top level.
// No dependencies.
`default_nettype none

package tma_pkg;

    localparam int MAX_WINDOW  = 64;
    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = 8;

    localparam int WIN_W  = 7;                               // window_length register
    localparam int CNT_W  = $clog2(MAX_WINDOW + 1);          // fill count and window
    localparam int SLOT_W = $clog2(MAX_WINDOW);              // ring slot index
    localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_WINDOW);
    localparam int DIV_W  = SUM_W + FRAC_BITS;               // scaled dividend
    localparam int OUT_W  = SAMPLE_BITS + FRAC_BITS;
    localparam int CMP_W  = (WIN_W > CNT_W) ? WIN_W : CNT_W;
    localparam int STEP_W = $clog2(DIV_W);
    localparam int WINDOW_RESET = 7;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIVIDE,
        ST_DONE
    } tma_state_t;

    typedef struct packed {
        logic accept;    // take the input transaction, issue history read
        logic update;    // update sum, count, ring; load the divider
        logic div_step;  // one restoring division step
        logic load_out;  // move the quotient to the output register
    } tma_cmd_t;

    typedef struct packed {
        logic out_free;  // output register can take a new result this cycle
    } tma_status_t;

endpackage

`default_nettype wire

// ===== sv/tma_if.sv =====
// Handshake interfaces for the sample, average and configuration channels.
// Depends on tma_pkg for the payload widths.
`default_nettype none

interface tma_sample_if ();
    logic                               valid;
    logic                               ready;
    logic [tma_pkg::SAMPLE_BITS-1:0]    sample;
    logic                               series_start;

    modport source (output valid, output sample, output series_start, input ready);
    modport sink   (input valid, input sample, input series_start, output ready);
endinterface

interface tma_average_if ();
    logic                           valid;
    logic                           ready;
    logic [tma_pkg::OUT_W-1:0]      average;

    modport source (output valid, output average, input ready);
    modport sink   (input valid, input average, output ready);
endinterface

interface tma_cfg_if ();
    logic                           valid;
    logic                           ready;
    logic [tma_pkg::WIN_W-1:0]      window_length;

    modport source (output valid, output window_length, input ready);
    modport sink   (input valid, input window_length, output ready);
endinterface

`default_nettype wire

// ===== sv/trailing_moving_average.sv =====
// Trailing moving average, top level. An accepted sample transaction goes through
// an update step, 30 restoring divider steps over the 30-bit scaled sum and an
// output load before its average is valid. A new sample is taken only once the
// last one has reached the output register; it is taken while the last average
// still waits. Reset: window 7, sum, count and ring slot cleared; the history
// memory is not cleared and needs no clearing pass.
`default_nettype none

module trailing_moving_average (
    input  wire             clk,
    input  wire             rst_n,
    tma_sample_if.sink      sample_ch,
    tma_average_if.source   average_ch,
    tma_cfg_if.sink         cfg
);

    tma_pkg::tma_cmd_t      cmd;
    tma_pkg::tma_status_t   status;
    logic                   in_ready;
    logic                   cfg_write;

    assign cfg.ready       = 1'b1;
    assign cfg_write       = cfg.valid;
    assign sample_ch.ready = in_ready;

    tma_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample_ch.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    tma_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .sample       (sample_ch.sample),
        .series_start (sample_ch.series_start),
        .cfg_write    (cfg_write),
        .cfg_window   (cfg.window_length),
        .average      (average_ch.average),
        .out_valid    (average_ch.valid),
        .out_ready    (average_ch.ready)
    );

endmodule

`default_nettype wire

// ===== sv/tma_ctrl.sv =====
// Controller state machine: sequences accept, update, division and output load.
// Depends on tma_pkg for the state, command and status types.
`default_nettype none

module tma_ctrl (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       in_valid,
    output logic                      in_ready,
    input  tma_pkg::tma_status_t      status,
    output tma_pkg::tma_cmd_t         cmd
);

    tma_pkg::tma_state_t           state_reg, state_next;
    logic [tma_pkg::STEP_W-1:0]    step_reg, step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tma_pkg::ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            tma_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = tma_pkg::ST_UPDATE;
                end
            end
            tma_pkg::ST_UPDATE:
            begin
                cmd.update = 1'b1;
                step_next  = tma_pkg::STEP_W'(tma_pkg::DIV_W - 1);
                state_next = tma_pkg::ST_DIVIDE;
            end
            tma_pkg::ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (step_reg == '0)
                begin
                    state_next = tma_pkg::ST_DONE;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
            tma_pkg::ST_DONE:
            begin
                // Wait here while the previous result has not been taken.
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = tma_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tma_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/tma_datapath.sv =====
// Datapath: window register, history ring memory, running sum, fill count,
// restoring divider and output register. Depends on tma_pkg.
`default_nettype none

module tma_datapath (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  tma_pkg::tma_cmd_t                   cmd,
    output tma_pkg::tma_status_t                status,
    input  wire [tma_pkg::SAMPLE_BITS-1:0]      sample,
    input  wire                                 series_start,
    input  wire                                 cfg_write,
    input  wire [tma_pkg::WIN_W-1:0]            cfg_window,
    output logic [tma_pkg::OUT_W-1:0]           average,
    output logic                                out_valid,
    input  wire                                 out_ready
);

    logic [tma_pkg::SAMPLE_BITS-1:0] history [tma_pkg::MAX_WINDOW];

    logic [tma_pkg::WIN_W-1:0]       window_reg;
    logic [tma_pkg::SUM_W-1:0]       sum_reg;
    logic [tma_pkg::CNT_W-1:0]       fill_reg;
    logic [tma_pkg::SLOT_W-1:0]      slot_reg;
    logic [tma_pkg::SAMPLE_BITS-1:0] sample_reg;
    logic [tma_pkg::SAMPLE_BITS-1:0] old_sample_reg;
    logic [tma_pkg::DIV_W-1:0]       quot_reg;
    logic [tma_pkg::CNT_W:0]         rem_reg;
    logic [tma_pkg::OUT_W-1:0]       average_reg;
    logic                            out_valid_reg;

    logic [tma_pkg::CMP_W-1:0]       window_ext;
    logic [tma_pkg::CNT_W-1:0]       window_eff;
    logic [tma_pkg::CNT_W-1:0]       slot_ext;
    logic [tma_pkg::SLOT_W-1:0]      old_slot;
    logic                            full;
    logic [tma_pkg::SUM_W-1:0]       sum_next;
    logic [tma_pkg::CNT_W-1:0]       fill_next;
    logic [tma_pkg::CNT_W:0]         trial;
    logic                            fits;

    // Window zero acts as one; values above the ring depth saturate.
    always_comb
    begin
        window_ext = tma_pkg::CMP_W'(window_reg);
        if (window_ext == '0)
        begin
            window_eff = tma_pkg::CNT_W'(1);
        end
        else if (window_ext > tma_pkg::CMP_W'(tma_pkg::MAX_WINDOW))
        begin
            window_eff = tma_pkg::CNT_W'(tma_pkg::MAX_WINDOW);
        end
        else
        begin
            window_eff = tma_pkg::CNT_W'(window_ext);
        end
    end

    // Slot of the sample that leaves the window, modulo the ring depth.
    always_comb
    begin
        slot_ext = tma_pkg::CNT_W'(slot_reg);
        if (slot_ext >= window_eff)
        begin
            old_slot = tma_pkg::SLOT_W'(slot_ext - window_eff);
        end
        else
        begin
            old_slot = tma_pkg::SLOT_W'(slot_ext + tma_pkg::CNT_W'(tma_pkg::MAX_WINDOW)
                                        - window_eff);
        end
    end

    always_comb
    begin
        full = (fill_reg >= window_eff);
        if (full)
        begin
            sum_next  = sum_reg - tma_pkg::SUM_W'(old_sample_reg)
                        + tma_pkg::SUM_W'(sample_reg);
            fill_next = window_eff;
        end
        else
        begin
            sum_next  = sum_reg + tma_pkg::SUM_W'(sample_reg);
            fill_next = fill_reg + 1'b1;
        end
    end

    always_comb
    begin
        trial = {rem_reg[tma_pkg::CNT_W-1:0], quot_reg[tma_pkg::DIV_W-1]};
        fits  = (trial >= {1'b0, fill_reg});
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            history[slot_reg] <= sample_reg;
        end
        if (cmd.accept)
        begin
            old_sample_reg <= history[old_slot];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            sample_reg <= sample;
        end
        if (cmd.update)
        begin
            // Dividend carries the half-divisor so the quotient rounds to nearest.
            quot_reg <= (tma_pkg::DIV_W'(sum_next) << tma_pkg::FRAC_BITS)
                        + tma_pkg::DIV_W'(fill_next >> 1);
            rem_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            if (fits)
            begin
                rem_reg  <= trial - {1'b0, fill_reg};
                quot_reg <= {quot_reg[tma_pkg::DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= trial;
                quot_reg <= {quot_reg[tma_pkg::DIV_W-2:0], 1'b0};
            end
        end
        if (cmd.load_out)
        begin
            average_reg <= quot_reg[tma_pkg::OUT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg    <= tma_pkg::WIN_W'(tma_pkg::WINDOW_RESET);
            sum_reg       <= '0;
            fill_reg      <= '0;
            slot_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                window_reg <= cfg_window;
                sum_reg    <= '0;
                fill_reg   <= '0;
            end
            else if (cmd.accept && series_start)
            begin
                sum_reg  <= '0;
                fill_reg <= '0;
            end
            else if (cmd.update)
            begin
                sum_reg  <= sum_next;
                fill_reg <= fill_next;
                if (slot_reg == tma_pkg::SLOT_W'(tma_pkg::MAX_WINDOW - 1))
                begin
                    slot_reg <= '0;
                end
                else
                begin
                    slot_reg <= slot_reg + 1'b1;
                end
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.out_free = !out_valid_reg || out_ready;
    assign average         = average_reg;
    assign out_valid       = out_valid_reg;

endmodule

`default_nettype wire

// ===== verif/tb_trailing_moving_average.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for trailing_moving_average: directed window and series
// tests, then random window phases, all checked against a running-sum predictor.
// Depends on tma_pkg, the tma_*_if interfaces and the trailing_moving_average block.

module tb_trailing_moving_average;
    import tma_pkg::*;

    localparam int CLK_PERIOD    = 8;
    localparam int RESET_CYCLES  = 4;
    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_LIMIT   = 2000;
    localparam int IDLE_PERCENT  = 33;
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;

    logic clk;
    logic rst_n;

    tma_sample_if  sample_ch ();
    tma_average_if average_ch ();
    tma_cfg_if     cfg_ch ();

    trailing_moving_average dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample_ch  (sample_ch),
        .average_ch (average_ch),
        .cfg        (cfg_ch)
    );

    // Predictor copy of the window register and the averaging state.
    logic [WIN_W-1:0]       window_reg;
    logic [SAMPLE_BITS-1:0] history [MAX_WINDOW];
    logic [SUM_W-1:0]       window_sum;
    int unsigned            window_fill;
    logic [SLOT_W-1:0]      next_slot;

    logic [OUT_W-1:0] expected_averages [$];
    int               mismatches;
    int               quiet_cycles;
    bit               no_idling;

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    function automatic logic [OUT_W-1:0] predict_average(input logic [SAMPLE_BITS-1:0] s,
                                                         input logic restart);
        int unsigned       span;
        logic [SLOT_W-1:0] old_slot;
        longint unsigned   scaled;
        span = (window_reg == 0) ? 1 : window_reg;
        if (span > MAX_WINDOW)
            span = MAX_WINDOW;
        if (restart)
        begin
            window_sum  = '0;
            window_fill = 0;
        end
        if (window_fill >= span)
        begin
            // The oldest sample leaves the window; at the full ring size it is
            // the one in the slot about to be overwritten.
            old_slot    = next_slot - SLOT_W'(span);
            window_sum  = window_sum - history[old_slot];
            window_fill = span;
        end
        else
            window_fill++;
        history[next_slot] = s;
        window_sum = window_sum + s;
        next_slot  = next_slot + 1'b1;
        scaled = window_sum;
        scaled = (scaled << FRAC_BITS) + (window_fill >> 1);
        return OUT_W'(scaled / window_fill);
    endfunction

    // Sink side: random stalls on the average channel.
    always @(posedge clk)
        average_ch.ready <= no_idling || ($urandom_range(99) >= IDLE_PERCENT);

    always @(posedge clk)
    begin : check_averages
        logic [OUT_W-1:0] want;
        if (rst_n && average_ch.valid && average_ch.ready)
        begin
            if (expected_averages.size() == 0)
            begin
                mismatches++;
                $display("%0t: average mismatch: expected none, actual %0d",
                         $time, average_ch.average);
            end
            else
            begin
                want = expected_averages.pop_front();
                if (average_ch.average !== want)
                begin
                    mismatches++;
                    $display("%0t: average mismatch: expected %0d, actual %0d",
                             $time, want, average_ch.average);
                end
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if ((sample_ch.valid && sample_ch.ready) || (average_ch.valid && average_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("** trailing_moving_average: FAILED **");
            $finish;
        end
    end

    task automatic send_sample(input logic [SAMPLE_BITS-1:0] s, input logic restart);
        while (!no_idling && $urandom_range(99) < IDLE_PERCENT)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid        <= 1'b1;
        sample_ch.sample       <= s;
        sample_ch.series_start <= restart;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        expected_averages.push_back(predict_average(s, restart));
    endtask

    // Stops the sender and waits until every outstanding average is back.
    task automatic drain_averages();
        sample_ch.valid <= 1'b0;
        while (expected_averages.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_window(input logic [WIN_W-1:0] value);
        drain_averages();
        cfg_ch.valid         <= 1'b1;
        cfg_ch.window_length <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        // Any window write starts a fresh warm-up.
        window_reg  = value;
        window_sum  = '0;
        window_fill = 0;
    endtask

    // Reset window, and a first sample that carries no start flag.
    task automatic test_first_without_start();
        logic [SAMPLE_BITS-1:0] vals [10] = '{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0001,
                                              16'h0002, 16'h8000, 16'hFFFF, 16'h0000,
                                              16'h0003, 16'h7FFF};
        foreach (vals[i])
            send_sample(vals[i], 1'b0);
    endtask

    task automatic test_window_one();
        write_window(7'd1);
        send_sample(SAMPLE_MAX, 1'b1);
        send_sample(16'h0000, 1'b0);
        send_sample(16'h1234, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
    endtask

    task automatic test_window_zero();
        write_window(7'd0);
        send_sample(16'hABCD, 1'b0);
        send_sample(SAMPLE_MAX, 1'b1);
    endtask

    task automatic test_window_oversize();
        write_window(7'd127);
        send_sample(16'd1, 1'b1);
        send_sample(16'd2, 1'b0);
        send_sample(16'd2, 1'b0);
    endtask

    task automatic test_series_restart();
        write_window(7'd3);
        send_sample(16'd5, 1'b1);
        send_sample(16'd6, 1'b0);
        send_sample(16'd7, 1'b0);
        send_sample(16'd9, 1'b1);
        send_sample(16'd0, 1'b0);
        send_sample(16'd1, 1'b1);
    endtask

    // The sender holds off until the pipeline is empty, then carries on in the
    // same series.
    task automatic test_paused_sender();
        write_window(7'd5);
        for (int i = 0; i < 6; i++)
            send_sample(SAMPLE_BITS'($urandom), i == 0);
        drain_averages();
        for (int i = 0; i < 6; i++)
            send_sample(SAMPLE_BITS'($urandom), 1'b0);
    endtask

    task automatic test_random_windows();
        logic [WIN_W-1:0]       value;
        logic [SAMPLE_BITS-1:0] s;
        logic                   restart;
        int unsigned            span;
        int unsigned            count;
        int unsigned            start_odds;
        for (int phase = 0; phase < 13; phase++)
        begin
            case (phase)
                0: value = 7'd64;
                1: value = 7'd1;
                2: value = 7'd127;
                3: value = 7'd0;
                4: value = 7'd2;
                5: value = 7'd65;
                6: value = 7'd63;
                default: value = WIN_W'($urandom_range(127));
            endcase
            write_window(value);
            span = (value == 0) ? 1 : ((value > MAX_WINDOW) ? MAX_WINDOW : value);
            count      = (span >= 16) ? 100 : 60;
            start_odds = (span >= 16) ? 80 : 15;
            // The first phase runs without any stalls and drives the sum to its top.
            no_idling = (phase == 0);
            for (int i = 0; i < count; i++)
            begin
                restart = ($urandom_range(start_odds - 1) == 0);
                if (phase == 0 && i < 80)
                begin
                    s       = SAMPLE_MAX;
                    restart = 1'b0;
                end
                else
                    case ($urandom_range(9))
                        0, 1, 2, 3, 4: s = SAMPLE_BITS'($urandom);
                        5, 6: s = $urandom_range(1) ? SAMPLE_MAX : SAMPLE_BITS'(0);
                        7, 8: s = SAMPLE_BITS'($urandom_range(3));
                        default: s = SAMPLE_MAX - SAMPLE_BITS'($urandom_range(7));
                    endcase
                send_sample(s, restart);
                if ($urandom_range(99) == 0)
                    drain_averages();
            end
            no_idling = 1'b0;
        end
    endtask

    initial
    begin
        sample_ch.valid        = 1'b0;
        sample_ch.sample       = '0;
        sample_ch.series_start = 1'b0;
        average_ch.ready       = 1'b0;
        cfg_ch.valid           = 1'b0;
        cfg_ch.window_length   = '0;
        no_idling    = 1'b0;
        mismatches   = 0;
        quiet_cycles = 0;
        window_reg   = WIN_W'(WINDOW_RESET);
        window_sum   = '0;
        window_fill  = 0;
        next_slot    = '0;
        rst_n        = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        test_first_without_start();
        test_window_one();
        test_window_zero();
        test_window_oversize();
        test_series_restart();
        test_paused_sender();
        test_random_windows();

        drain_averages();
        if (mismatches == 0)
            $display("** trailing_moving_average: PASSED **");
        else
            $display("** trailing_moving_average: FAILED **");
        $finish;
    end

endmodule

// ===== files.f =====
sv/tma_pkg.sv
sv/tma_if.sv
sv/tma_ctrl.sv
sv/tma_datapath.sv
sv/trailing_moving_average.sv
verif/tb_trailing_moving_average.sv
